>>> rtl/aids_pkg.sv
// Shared types and constants for the array insert/delete/search block.
// Used by aids_seq, the top level and the checker; depends on nothing.
package aids_pkg;

	localparam int DEPTH       = 64;
	localparam int MAX_RESULTS = 64;
	localparam int WW          = 32;
	localparam int POS_W       = 6;
	localparam int CNT_OUT_W   = 7;
	localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int HW          = $clog2(MAX_RESULTS + 1);
	localparam int PCW         = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		REQ_APPEND = 3'd0,
		REQ_READ   = 3'd1,
		REQ_INSERT = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_SEARCH = 3'd4
	} req_e;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_RANGE    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} stat_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_SHUP,
		S_PUT,
		S_SHDN,
		S_SCAN
	} state_e;

	typedef struct packed {
		stat_e                  status;
		logic [WW-1:0]          word_out;
		logic [POS_W-1:0]       found_at;
		logic [CNT_OUT_W-1:0]   used_count;
		logic                   last;
	} res_t;

	typedef struct packed {
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [WW-1:0] wr_data;
		logic          rd_en;
		logic [AW-1:0] rd_addr;
	} mem_req_t;

endpackage

>>> rtl/aids_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aids_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/aids_seq.sv
// Request sequencer: decodes a request, walks the element RAM one entry per
// cycle (a search can wait for output space) through the shared read/compare
// path and produces result words. Depends on aids_pkg.
module aids_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                req_type,
	input  logic [aids_pkg::POS_W-1:0] position,
	input  logic [aids_pkg::WW-1:0]    word_in,
	input  logic                      out_space,
	output logic                      emit,
	output aids_pkg::res_t            res,
	output aids_pkg::mem_req_t        mem_req,
	input  logic [aids_pkg::WW-1:0]    rd_data
);

	aids_pkg::state_e              state_q, state_d;
	logic [aids_pkg::CW-1:0]       count_q, count_d;
	logic [aids_pkg::WW-1:0]       key_q, key_d;
	logic [aids_pkg::AW-1:0]       pos_q, pos_d;
	logic [aids_pkg::AW-1:0]       wr_q, wr_d;
	logic [aids_pkg::AW-1:0]       cmp_q, cmp_d;
	logic [aids_pkg::HW-1:0]       hits_q, hits_d;
	logic                          pend_q, pend_d;
	logic [aids_pkg::AW-1:0]       pend_idx_q, pend_idx_d;
	aids_pkg::stat_e               status_q, status_d;
	logic [aids_pkg::AW-1:0]       found_q, found_d;
	logic                          use_rd_q, use_rd_d;

	logic [aids_pkg::PCW-1:0]      pos_w, cnt_w;
	logic                          full, match, scan_end;

	assign pos_w    = aids_pkg::PCW'(position);
	assign cnt_w    = aids_pkg::PCW'(count_q);
	assign full     = (count_q == aids_pkg::CW'(aids_pkg::DEPTH));
	assign match    = (rd_data == key_q);
	assign in_stall = (state_q != aids_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aids_pkg::S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			hits_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			hits_q  <= hits_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q      <= key_d;
		pos_q      <= pos_d;
		wr_q       <= wr_d;
		cmp_q      <= cmp_d;
		pend_idx_q <= pend_idx_d;
		status_q   <= status_d;
		found_q    <= found_d;
		use_rd_q   <= use_rd_d;
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		key_d      = key_q;
		pos_d      = pos_q;
		wr_d       = wr_q;
		cmp_d      = cmp_q;
		hits_d     = hits_q;
		pend_d     = pend_q;
		pend_idx_d = pend_idx_q;
		status_d   = status_q;
		found_d    = found_q;
		use_rd_d   = use_rd_q;
		scan_end   = 1'b0;
		mem_req    = '0;
		emit       = 1'b0;

		res.status     = status_q;
		res.word_out   = use_rd_q ? rd_data : '0;
		res.found_at   = aids_pkg::POS_W'(found_q);
		res.used_count = aids_pkg::CNT_OUT_W'(count_q);
		res.last       = 1'b1;

		unique case (state_q)
			aids_pkg::S_IDLE: begin
				if (in_valid) begin
					key_d    = word_in;
					pos_d    = aids_pkg::AW'(position);
					use_rd_d = 1'b0;
					found_d  = '0;
					status_d = aids_pkg::STAT_OK;
					state_d  = aids_pkg::S_RESP;
					unique case (aids_pkg::req_e'(req_type))
						aids_pkg::REQ_APPEND: begin
							if (full) begin
								status_d = aids_pkg::STAT_FULL;
							end else begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = aids_pkg::AW'(count_q);
								mem_req.wr_data = word_in;
								count_d         = count_q + aids_pkg::CW'(1);
							end
						end
						aids_pkg::REQ_READ: begin
							if (pos_w >= cnt_w) begin
								status_d = aids_pkg::STAT_RANGE;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = aids_pkg::AW'(position);
								use_rd_d        = 1'b1;
							end
						end
						aids_pkg::REQ_INSERT: begin
							if (pos_w > cnt_w) begin
								status_d = aids_pkg::STAT_RANGE;
							end else if (full) begin
								status_d = aids_pkg::STAT_FULL;
							end else if (pos_w == cnt_w) begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = aids_pkg::AW'(count_q);
								mem_req.wr_data = word_in;
								count_d         = count_q + aids_pkg::CW'(1);
							end else begin
								// tail moves up from the top entry down to position
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = aids_pkg::AW'(count_q - aids_pkg::CW'(1));
								wr_d            = aids_pkg::AW'(count_q);
								state_d         = aids_pkg::S_SHUP;
							end
						end
						aids_pkg::REQ_DELETE: begin
							if (pos_w >= cnt_w) begin
								status_d = aids_pkg::STAT_RANGE;
							end else if (pos_w + aids_pkg::PCW'(1) == cnt_w) begin
								count_d = count_q - aids_pkg::CW'(1);
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = aids_pkg::AW'(pos_w + aids_pkg::PCW'(1));
								wr_d            = aids_pkg::AW'(position);
								state_d         = aids_pkg::S_SHDN;
							end
						end
						aids_pkg::REQ_SEARCH: begin
							if (count_q == '0) begin
								status_d = aids_pkg::STAT_NOTFOUND;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = '0;
								cmp_d           = '0;
								hits_d          = '0;
								pend_d          = 1'b0;
								state_d         = aids_pkg::S_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
			end

			aids_pkg::S_SHUP: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = wr_q;
				mem_req.wr_data = rd_data;
				if (wr_q - aids_pkg::AW'(1) == pos_q) begin
					state_d = aids_pkg::S_PUT;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = wr_q - aids_pkg::AW'(2);
					wr_d            = wr_q - aids_pkg::AW'(1);
				end
			end

			aids_pkg::S_PUT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = pos_q;
				mem_req.wr_data = key_q;
				count_d         = count_q + aids_pkg::CW'(1);
				state_d         = aids_pkg::S_RESP;
			end

			aids_pkg::S_SHDN: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = wr_q;
				mem_req.wr_data = rd_data;
				if (aids_pkg::CW'(wr_q) + aids_pkg::CW'(2) == count_q) begin
					count_d = count_q - aids_pkg::CW'(1);
					state_d = aids_pkg::S_RESP;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = wr_q + aids_pkg::AW'(2);
					wr_d            = wr_q + aids_pkg::AW'(1);
				end
			end

			aids_pkg::S_SCAN: begin
				// one hit is held back so the final one can carry last
				if (!(match && pend_q && !out_space)) begin
					if (match && pend_q) begin
						emit           = 1'b1;
						res.status     = aids_pkg::STAT_OK;
						res.word_out   = '0;
						res.found_at   = aids_pkg::POS_W'(pend_idx_q);
						res.last       = 1'b0;
					end
					if (match) begin
						pend_d     = 1'b1;
						pend_idx_d = cmp_q;
						hits_d     = hits_q + aids_pkg::HW'(1);
					end
					scan_end = (aids_pkg::CW'(cmp_q) + aids_pkg::CW'(1) == count_q) ||
						(match && (hits_q + aids_pkg::HW'(1) == aids_pkg::HW'(aids_pkg::MAX_RESULTS)));
					if (scan_end) begin
						status_d = (match || pend_q) ? aids_pkg::STAT_OK : aids_pkg::STAT_NOTFOUND;
						found_d  = match ? cmp_q : (pend_q ? pend_idx_q : '0);
						state_d  = aids_pkg::S_RESP;
					end else begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = cmp_q + aids_pkg::AW'(1);
						cmp_d           = cmp_q + aids_pkg::AW'(1);
					end
				end
			end

			aids_pkg::S_RESP: begin
				if (out_space) begin
					emit    = 1'b1;
					state_d = aids_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = aids_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/array_insert_delete_search.sv
// Requests that need no walk (append, read, errors, unknown codes) go from accept through
// S_RESP to the output register; shifting inserts first pass S_SHUP and S_PUT, shifting
// deletes S_SHDN and searches S_SCAN. Output stalls hold S_RESP and can pause S_SCAN.
// Throughput: one request at a time; each walk moves one RAM entry per cycle through the
// single read port, except while a search waits for output space.
// Reset: count cleared and output register emptied at once; RAM contents are undefined
// until written, and no clearing pass is run.
module array_insert_delete_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        req_type,
	input  logic [aids_pkg::POS_W-1:0]        position,
	input  logic signed [aids_pkg::WW-1:0]    word_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [aids_pkg::WW-1:0]    word_out,
	output logic [aids_pkg::POS_W-1:0]        found_at,
	output logic [aids_pkg::CNT_OUT_W-1:0]    used_count,
	output logic                              last
);

	aids_pkg::mem_req_t       mem_req;
	aids_pkg::res_t           res, res_q;
	logic [aids_pkg::WW-1:0]  rd_data;
	logic                     emit, out_space, out_valid_q;

	assign out_space = !out_valid_q || !out_stall;

	aids_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.position  (position),
		.word_in   (word_in),
		.out_space (out_space),
		.emit      (emit),
		.res       (res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	aids_ram #(
		.WIDTH (aids_pkg::WW),
		.DEPTH (aids_pkg::DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

	// output word register: loads only when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = res_q.status;
	assign word_out   = res_q.word_out;
	assign found_at   = res_q.found_at;
	assign used_count = res_q.used_count;
	assign last       = res_q.last;

endmodule

>>> rtl/aids_checker.sv
// Port-level checker for array_insert_delete_search, attached by bind.
// Depends on aids_pkg.
module aids_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [1:0]                        status,
	input logic signed [aids_pkg::WW-1:0]    word_out,
	input logic [aids_pkg::POS_W-1:0]        found_at,
	input logic [aids_pkg::CNT_OUT_W-1:0]    used_count,
	input logic                              last
);

	// a taken request always raises in_stall in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took a request and stayed ready");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(used_count) <= aids_pkg::DEPTH))
		else $error("used_count above DEPTH");

	// any error or not-found word ends its request
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 2'(aids_pkg::STAT_OK)) |-> last)
		else $error("error word without last");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == 2'(aids_pkg::STAT_NOTFOUND)) |->
			(found_at == '0) && (word_out == '0))
		else $error("not-found word carries data");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_at) &&
			$stable(last))
		else $error("stalled output word changed");

endmodule

bind array_insert_delete_search aids_checker u_aids_checker (.*);

>>> tb/sv/tb.sv
// Self-checking bench for array_insert_delete_search: queued requests, burst driver,
// random output stalls, and an in-bench array predictor checked word by word.
// Depends on aids_pkg and the array_insert_delete_search RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [2:0] REQ_NOP_A = 3'd5;
	localparam logic [2:0] REQ_NOP_B = 3'd6;
	localparam logic [2:0] REQ_NOP_C = 3'd7;

	typedef struct packed {
		logic [2:0]  rq;
		logic [5:0]  pos;
		logic [31:0] wd;
		logic        hold;
	} req_word_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [aids_pkg::POS_W-1:0] position = '0;
	logic signed [aids_pkg::WW-1:0] word_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic signed [aids_pkg::WW-1:0] word_out;
	logic [aids_pkg::POS_W-1:0] found_at;
	logic [aids_pkg::CNT_OUT_W-1:0] used_count;
	logic last;

	// predictor state
	logic [31:0] arr_mem [aids_pkg::DEPTH];
	int arr_cnt = 0;
	aids_pkg::res_t want_res[$];
	int n_pred = 0;
	int n_checked = 0;

	// stimulus
	req_word_t req_backlog[$];
	int plan_cnt = 0;
	int n_queued = 0;
	int n_live = 0;
	int n_sent = 0;

	int fail_count = 0;
	int cycle_cnt = 0;

	int burst_left = 0;
	int gap_left = 0;
	req_word_t nxt;

	stall_mode_e stall_mode = STALL_NONE;
	int mode_left = 0;
	int run_left = 0;
	bit run_stall = 1'b0;

	aids_pkg::res_t got;
	aids_pkg::res_t want;

	array_insert_delete_search DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.position(position),
		.word_in(word_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.word_out(word_out),
		.found_at(found_at),
		.used_count(used_count),
		.last(last)
	);

	always #6 clk = ~clk;

	// apply one accepted request to the shadow array, queue the words it should produce
	task automatic run_array_op(input logic [2:0] rq, input logic [5:0] pos,
			input logic [31:0] wd);
		aids_pkg::res_t r;
		int i;
		int k;
		int hits;
		bit multi;
		r = '0;
		r.status = aids_pkg::STAT_OK;
		r.last = 1'b1;
		multi = 1'b0;
		case (rq)
			aids_pkg::REQ_APPEND: begin
				if (arr_cnt >= aids_pkg::DEPTH) begin
					r.status = aids_pkg::STAT_FULL;
				end else begin
					arr_mem[arr_cnt] = wd;
					arr_cnt++;
				end
			end
			aids_pkg::REQ_READ: begin
				if (pos >= arr_cnt) r.status = aids_pkg::STAT_RANGE;
				else r.word_out = arr_mem[pos];
			end
			aids_pkg::REQ_INSERT: begin
				if (pos > arr_cnt) begin
					r.status = aids_pkg::STAT_RANGE;
				end else if (arr_cnt >= aids_pkg::DEPTH) begin
					r.status = aids_pkg::STAT_FULL;
				end else begin
					for (i = arr_cnt; i > pos; i--)
						arr_mem[i] = arr_mem[i - 1];
					arr_mem[pos] = wd;
					arr_cnt++;
				end
			end
			aids_pkg::REQ_DELETE: begin
				if (pos >= arr_cnt) begin
					r.status = aids_pkg::STAT_RANGE;
				end else begin
					for (i = pos; i + 1 < arr_cnt; i++)
						arr_mem[i] = arr_mem[i + 1];
					arr_cnt--;
				end
			end
			aids_pkg::REQ_SEARCH: begin
				multi = 1'b1;
				r.used_count = 7'(arr_cnt);
				hits = 0;
				for (i = 0; i < arr_cnt && hits < aids_pkg::MAX_RESULTS; i++)
					if (arr_mem[i] == wd) hits++;
				if (hits == 0) begin
					r.status = aids_pkg::STAT_NOTFOUND;
					want_res.push_back(r);
					n_pred++;
				end else begin
					k = 0;
					for (i = 0; i < arr_cnt && k < hits; i++) begin
						if (arr_mem[i] == wd) begin
							r.found_at = 6'(i);
							r.last = (k == hits - 1);
							want_res.push_back(r);
							n_pred++;
							k++;
						end
					end
				end
			end
			default: ;
		endcase
		if (!multi) begin
			r.used_count = 7'(arr_cnt);
			want_res.push_back(r);
			n_pred++;
		end
	endtask

	task automatic queue_req(input logic [2:0] rq, input logic [5:0] pos,
			input logic [31:0] wd, input bit hold);
		req_word_t w;
		w.rq = rq;
		w.pos = pos;
		w.wd = wd;
		w.hold = hold;
		req_backlog.push_back(w);
		n_queued++;
		if (rq <= aids_pkg::REQ_SEARCH) n_live++;
		case (rq)
			aids_pkg::REQ_APPEND: if (plan_cnt < aids_pkg::DEPTH) plan_cnt++;
			aids_pkg::REQ_INSERT: if (pos <= plan_cnt && plan_cnt < aids_pkg::DEPTH) plan_cnt++;
			aids_pkg::REQ_DELETE: if (pos < plan_cnt) plan_cnt--;
			default: ;
		endcase
	endtask

	// small pool so that searches hit, plus extremes and full-width noise
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return 32'h0000_0011;
			4, 5: return 32'hffff_ffef;
			6: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_mix(input int n, input bit shrink);
		int k;
		int roll;
		logic [5:0] p;
		bit hold;
		for (k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			hold = (k == 0) && ($urandom_range(0, 9) == 0);
			if (roll < (shrink ? 10 : 30)) begin
				queue_req(aids_pkg::REQ_APPEND, 6'($urandom_range(0, 63)), pick_word(), hold);
			end else if (roll < (shrink ? 20 : 50)) begin
				if ($urandom_range(0, 9) == 0) p = 6'($urandom_range(0, 63));
				else p = 6'($urandom_range(0, (plan_cnt > 63) ? 63 : plan_cnt));
				queue_req(aids_pkg::REQ_INSERT, p, pick_word(), hold);
			end else if (roll < (shrink ? 75 : 85)) begin
				if (plan_cnt == 0 || $urandom_range(0, 9) == 0) p = 6'($urandom_range(0, 63));
				else p = 6'($urandom_range(0, plan_cnt - 1));
				queue_req((roll < (shrink ? 65 : 70)) ? aids_pkg::REQ_DELETE : aids_pkg::REQ_READ,
					p, $urandom(), hold);
			end else begin
				queue_req(aids_pkg::REQ_SEARCH, 6'($urandom_range(0, 63)), pick_word(), hold);
			end
		end
	endtask

	// empty the array, fill it with one value, then work the full-array corners
	task automatic queue_fill();
		logic [31:0] a;
		logic [31:0] b;
		a = $urandom();
		b = ~a;
		while (plan_cnt > 0)
			queue_req(aids_pkg::REQ_DELETE, 6'($urandom_range(0, plan_cnt - 1)), $urandom(),
				1'b0);
		queue_req(aids_pkg::REQ_APPEND, 6'd0, a, 1'b1);
		while (plan_cnt < aids_pkg::DEPTH) begin
			if ($urandom_range(0, 3) == 0)
				queue_req(aids_pkg::REQ_INSERT, 6'($urandom_range(0, plan_cnt)), a, 1'b0);
			else
				queue_req(aids_pkg::REQ_APPEND, 6'($urandom_range(0, 63)), a, 1'b0);
		end
		queue_req(aids_pkg::REQ_APPEND, 6'd0, b, 1'b0);
		queue_req(aids_pkg::REQ_INSERT, 6'd0, b, 1'b0);
		queue_req(aids_pkg::REQ_INSERT, 6'd63, b, 1'b0);
		queue_req(aids_pkg::REQ_SEARCH, 6'd0, a, 1'b0);
		queue_req(aids_pkg::REQ_READ, 6'd63, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_READ, 6'd0, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_DELETE, 6'($urandom_range(0, 63)), 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_INSERT, 6'($urandom_range(0, 63)), b, 1'b0);
		queue_req(aids_pkg::REQ_SEARCH, 6'd0, b, 1'b0);
		queue_req(aids_pkg::REQ_SEARCH, 6'd0, a, 1'b0);
		queue_req(aids_pkg::REQ_DELETE, 6'd63, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_DELETE, 6'd0, 32'h0, 1'b0);
	endtask

	task automatic flag_error(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	// driver: bursts with random gaps, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				run_array_op(req_type, position, word_in);
				n_sent++;
			end
			if (in_valid && in_stall) begin
				// hold the current word
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() == 0 ||
					(req_backlog[0].hold && n_pred != n_checked)) begin
				in_valid <= 1'b0;
			end else begin
				nxt = req_backlog.pop_front();
				in_valid <= 1'b1;
				req_type <= nxt.rq;
				position <= nxt.pos;
				word_in <= nxt.wd;
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
						: $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
		end
	end

	// receiver stall pattern; the stall mode is re-picked at random when its run ends
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			if (run_left == 0) begin
				run_stall = !run_stall;
				run_left = $urandom_range(1, 8);
			end else begin
				run_left--;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= run_stall;
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.status = aids_pkg::stat_e'(status);
			got.word_out = word_out;
			got.found_at = found_at;
			got.used_count = used_count;
			got.last = last;
			if (want_res.size() == 0) begin
				flag_error($sformatf("unexpected result word st=%0d wo=%0d fa=%0d cnt=%0d last=%0b",
					got.status, $signed(got.word_out), got.found_at, got.used_count,
					got.last));
			end else begin
				want = want_res.pop_front();
				if (got.status !== want.status || got.word_out !== want.word_out ||
						got.found_at !== want.found_at ||
						got.used_count !== want.used_count || got.last !== want.last)
					flag_error($sformatf({"mismatch on result %0d: expected st=%0d wo=%0d ",
						"fa=%0d cnt=%0d last=%0b, got st=%0d wo=%0d fa=%0d cnt=%0d last=%0b"},
						n_checked, want.status, $signed(want.word_out), want.found_at,
						want.used_count, want.last, got.status, $signed(got.word_out),
						got.found_at, got.used_count, got.last));
			end
			n_checked <= n_checked + 1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("array_insert_delete_search test failed");
			$finish;
		end
	end

	initial begin
		// directed: empty-array errors, extremes, shifts, edge positions, undefined codes
		queue_req(aids_pkg::REQ_READ, 6'd0, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_DELETE, 6'd0, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_SEARCH, 6'd0, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_INSERT, 6'd1, 32'h1, 1'b0);
		queue_req(aids_pkg::REQ_INSERT, 6'd0, 32'h8000_0000, 1'b0);
		queue_req(aids_pkg::REQ_APPEND, 6'd63, 32'h7fff_ffff, 1'b0);
		queue_req(aids_pkg::REQ_APPEND, 6'd0, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_APPEND, 6'd0, 32'hffff_ffff, 1'b0);
		queue_req(aids_pkg::REQ_INSERT, 6'd1, 32'h5, 1'b0);
		queue_req(aids_pkg::REQ_INSERT, 6'd5, 32'hffff_ffff, 1'b0);
		queue_req(aids_pkg::REQ_READ, 6'd0, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_READ, 6'd5, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_READ, 6'd6, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_READ, 6'd63, 32'hffff_ffff, 1'b0);
		queue_req(aids_pkg::REQ_SEARCH, 6'd0, 32'hffff_ffff, 1'b0);
		queue_req(aids_pkg::REQ_SEARCH, 6'd0, 32'h1234_5678, 1'b0);
		queue_req(aids_pkg::REQ_DELETE, 6'd0, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_DELETE, 6'd4, 32'h0, 1'b0);
		queue_req(aids_pkg::REQ_DELETE, 6'd4, 32'h0, 1'b0);
		queue_req(REQ_NOP_A, 6'd63, 32'h7fff_ffff, 1'b0);
		queue_req(REQ_NOP_C, 6'd0, 32'h8000_0000, 1'b0);
		queue_req(aids_pkg::REQ_SEARCH, 6'd0, 32'h7fff_ffff, 1'b0);
		queue_req(REQ_NOP_B, 6'd21, 32'h0, 1'b0);

		queue_mix(15, 1'b0);
		queue_fill();
		while (n_live < 140) begin
			case ($urandom_range(0, 3))
				0, 1: queue_mix($urandom_range(8, 20), 1'b0);
				2: queue_mix($urandom_range(8, 20), 1'b1);
				default: begin
					repeat ($urandom_range(3, 8))
						queue_req(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
							$urandom(), 1'b0);
				end
			endcase
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (n_sent == n_queued);
		wait (n_checked == n_pred);
		repeat (aids_pkg::DEPTH + 16) @(posedge clk);
		if (fail_count == 0 && want_res.size() == 0)
			$display("array_insert_delete_search test passed");
		else
			$display("array_insert_delete_search test failed");
		$finish;
	end

endmodule
